>>> rtl/rlb_pkg.sv
// rlb_pkg: shared widths, register indexes, reset values, sine table and
// controller/datapath command and status types for the rgb led breathing block
// no dependencies
package rlb_pkg;

   // default generics
   localparam int unsigned SINE_STEPS_DEF = 21;
   localparam int unsigned DUTY_TOP_DEF   = 10000;

   // field widths
   localparam int unsigned DUTY_W      = 14;
   localparam int unsigned PERIOD_W    = 16;
   localparam int unsigned TICK_W      = 32;
   localparam int unsigned COLOR_W     = 3;
   localparam int unsigned MODE_W      = 2;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned REQ_DATA_W  = 40;
   localparam int unsigned RSP_DATA_W  = 48;
   localparam int unsigned SINE_W      = 16;
   localparam int unsigned SINE_IDX_W  = 7;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_SLOW_PERIOD = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FAST_PERIOD = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RED_PEAK    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_GREEN_PEAK  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_BLUE_PEAK   = 3'd4;

   // register reset values
   localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST = 16'd2000;
   localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST = 16'd500;
   localparam logic [DUTY_W-1:0]   RED_PEAK_RST    = 14'd2000;
   localparam logic [DUTY_W-1:0]   GREEN_PEAK_RST  = 14'd1000;
   localparam logic [DUTY_W-1:0]   BLUE_PEAK_RST   = 14'd7000;

   // modes
   localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ON   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SLOW = 2'd2;
   localparam logic [MODE_W-1:0] MODE_FAST = 2'd3;

   // channels
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   // divider operand selection
   localparam logic DIV_MOD = 1'b0;  // tick % period
   localparam logic DIV_IDX = 1'b1;  // phase / step length

   // half-sine samples, unsigned q1.15
   localparam int unsigned TABLE_LEN = 21;
   localparam logic [SINE_W-1:0] SINE_TABLE [TABLE_LEN] = '{
      16'd0,     16'd5125,  16'd10125, 16'd14877, 16'd19261, 16'd23170,
      16'd26509, 16'd29196, 16'd31166, 16'd32365, 16'd32768, 16'd32365,
      16'd31166, 16'd29196, 16'd26509, 16'd23170, 16'd19261, 16'd14877,
      16'd10125, 16'd5125,  16'd0
   };

   // table lookup with the index wrapped to the table length (index below 84)
   function automatic logic [SINE_W-1:0] sine_q15(input logic [SINE_IDX_W-1:0] idx);
      logic [SINE_IDX_W-1:0] r;
      r = idx;
      for (int k = 0; k < 3; k++) begin
         if (r >= SINE_IDX_W'(TABLE_LEN)) begin
            r = r - SINE_IDX_W'(TABLE_LEN);
         end
      end
      return SINE_TABLE[r[4:0]];
   endfunction

   // controller to datapath commands
   typedef struct packed {
      logic       accept;
      logic       div_start;
      logic       div_sel;
      logic       step_load;
      logic       idx_load;
      logic       sine_load;
      logic       mul_en;
      logic [1:0] ch;
      logic       glow_commit;
      logic       fin;
      logic       out_load;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic glow;
      logic over;
      logic div_done;
   } dp_status_type;

endpackage

>>> rtl/rgb_led_breathing_controller_top.sv
// rgb_led_breathing_controller_top: rgb led duty controller with sine glow
// joins rlb_ctrl and rlb_datapath; uses rlb_pkg
//
//   channel  direction  handshake            payload
//   req      in         req_tvalid/tready    tdata: color, mode, tick; tuser: cmd
//   rsp      out        rsp_tvalid/tready    tdata: red, green, blue duty, running
//   csr      in         csr_wen              csr_addr, csr_wdata
//
// a word outside the glow modes passes the step, finish and output states to the
// result register and a glow word whose step has not yet elapsed also passes the
// check state (step length from a reciprocal multiply); a glow update runs the
// one-bit-per-cycle divider twice: tick modulo period, then the step index.
// the input is accepted again once the previous word is in the result register,
// even while that result waits for rsp_tready. reset is synchronous, active high;
// it loads the register defaults and starts with playback flagged as running.
module rgb_led_breathing_controller_top #(
   parameter int unsigned SINE_STEPS = rlb_pkg::SINE_STEPS_DEF,
   parameter int unsigned DUTY_TOP   = rlb_pkg::DUTY_TOP_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_wen,
   input  logic [rlb_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [rlb_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // input words
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [2:0] color_code, [4:3] mode, [36:5] now_tick, [39:37] zero
   input  logic [rlb_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] cmd
   input  logic                              req_tuser,
   // result words
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [13:0] red_duty, [27:14] green_duty, [41:28] blue_duty,
   // [42] pwm_running, [47:43] zero
   output logic [rlb_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import rlb_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   rlb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rlb_datapath #(
      .SINE_STEPS (SINE_STEPS),
      .DUTY_TOP   (DUTY_TOP)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

>>> rtl/rlb_div.sv
// rlb_div: restoring divider, one quotient bit per cycle, 16 or 32 steps
// uses rlb_pkg for widths
module rlb_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            wide,
   input  logic [rlb_pkg::TICK_W-1:0]      dividend,
   input  logic [rlb_pkg::PERIOD_W-1:0]    divisor,
   output logic [rlb_pkg::TICK_W-1:0]      quotient,
   output logic [rlb_pkg::PERIOD_W-1:0]    remainder,
   output logic                            done
);
   import rlb_pkg::*;

   localparam logic [5:0] WIDE_STEPS   = 6'd32;
   localparam logic [5:0] NARROW_STEPS = 6'd16;

   logic [TICK_W-1:0]   quo_ff, quo_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [PERIOD_W-1:0] dvs_ff, dvs_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [PERIOD_W:0]   shifted;
   logic [PERIOD_W+1:0] diff;
   logic                ge;

   // one trial subtraction
   assign shifted = {rem_ff, quo_ff[TICK_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};
   assign ge      = ~diff[PERIOD_W+1];

   // next state
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = wide ? dividend : {dividend[PERIOD_W-1:0], {PERIOD_W{1'b0}}};
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = wide ? WIDE_STEPS : NARROW_STEPS;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[TICK_W-2:0], ge};
         rem_in = ge ? diff[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operand registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

>>> rtl/rlb_datapath.sv
// rlb_datapath: configuration registers, color and mode state, duty registers,
// glow phase arithmetic and result register; uses rlb_pkg and rlb_div
module rlb_datapath #(
   parameter int unsigned SINE_STEPS = rlb_pkg::SINE_STEPS_DEF,
   parameter int unsigned DUTY_TOP   = rlb_pkg::DUTY_TOP_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [rlb_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [rlb_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [rlb_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tuser,
   input  rlb_pkg::ctrl_cmd_type             cmd,
   output rlb_pkg::dp_status_type            status,
   output logic [rlb_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import rlb_pkg::*;

   localparam int unsigned IDX_W = $clog2(SINE_STEPS);
   localparam int unsigned Q_W   = IDX_W + 1;
   localparam logic [PERIOD_W-1:0] STEPS_P  = PERIOD_W'(SINE_STEPS);
   localparam logic [Q_W-1:0]      STEPS_Q  = Q_W'(SINE_STEPS);
   localparam logic [15:0]         TOP_16   = 16'(DUTY_TOP);

   // step length by reciprocal multiply: ceil(2^sh / steps), exact for 16-bit periods
   localparam int unsigned RECIP_SH = PERIOD_W + $clog2(SINE_STEPS);
   localparam int unsigned RECIP_W  = PERIOD_W + 1;
   localparam int unsigned PROD_W   = PERIOD_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_M =
      RECIP_W'(((64'd1 << RECIP_SH) + 64'(SINE_STEPS) - 64'd1) / 64'(SINE_STEPS));

   // configuration
   logic [PERIOD_W-1:0] slow_period_ff, slow_period_in;
   logic [PERIOD_W-1:0] fast_period_ff, fast_period_in;
   logic [DUTY_W-1:0]   peak_ff [3];
   logic [DUTY_W-1:0]   peak_in [3];

   // block state
   logic [COLOR_W-1:0]  color_ff, color_in, prev_color_ff, prev_color_in;
   logic [MODE_W-1:0]   mode_ff, mode_in, prev_mode_ff, prev_mode_in;
   logic [TICK_W-1:0]   last_ff, last_in;
   logic [DUTY_W-1:0]   duty_ff [3];
   logic [DUTY_W-1:0]   duty_in [3];
   logic                running_ff, running_in;

   // working registers
   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic [PERIOD_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [SINE_W-1:0]   sine_ff, sine_in;
   logic [RSP_DATA_W-1:0] rsp_ff, rsp_in;

   // combinational helpers
   logic [2:0]          en;
   logic [DUTY_W-1:0]   peak_sat [3];
   logic [PERIOD_W-1:0] period_sel, period_eff;
   logic [PROD_W-1:0]   step_prod;
   logic [TICK_W-1:0]   elapsed;
   logic [TICK_W-1:0]   div_dividend;
   logic [PERIOD_W-1:0] div_divisor;
   logic                div_wide;
   logic [TICK_W-1:0]   div_quo;
   logic [PERIOD_W-1:0] div_rem;
   logic                div_done;
   logic [Q_W-1:0]      q;
   logic [DUTY_W-1:0]   mul_peak;
   logic [SINE_W+DUTY_W-1:0] prod;
   logic                off_change;
   logic                on_load;

   // color code to red/green/blue enables
   always_comb begin
      unique case (color_ff)
         3'd0:    en = 3'b001;
         3'd1:    en = 3'b010;
         3'd2:    en = 3'b100;
         3'd3:    en = 3'b110;
         3'd4:    en = 3'b101;
         3'd5:    en = 3'b011;
         3'd6:    en = 3'b111;
         default: en = 3'b000;
      endcase
   end

   // peaks saturated to full scale
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         peak_sat[i] = ({2'b00, peak_ff[i]} > TOP_16) ? TOP_16[DUTY_W-1:0] : peak_ff[i];
      end
   end

   // period of the glow mode, raised to at least one tick per step
   assign period_sel = (mode_ff == MODE_SLOW) ? slow_period_ff : fast_period_ff;
   assign period_eff = (period_sel < STEPS_P) ? STEPS_P : period_sel;
   assign elapsed    = tick_ff - last_ff;

   // ticks per sine step
   assign step_prod = PROD_W'(period_eff) * PROD_W'(RECIP_M);

   // divider operand selection
   always_comb begin
      unique case (cmd.div_sel)
         DIV_MOD: begin
            div_dividend = tick_ff;
            div_divisor  = period_eff;
            div_wide     = 1'b1;
         end
         default: begin
            div_dividend = {{(TICK_W-PERIOD_W){1'b0}}, div_rem};
            div_divisor  = step_ff;
            div_wide     = 1'b0;
         end
      endcase
   end

   rlb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .wide      (div_wide),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   // step index wrapped once to the step count
   assign q = div_quo[Q_W-1:0];

   // one channel a cycle through the multiplier
   always_comb begin
      unique case (cmd.ch)
         CH_RED:   mul_peak = peak_sat[0];
         CH_GREEN: mul_peak = peak_sat[1];
         CH_BLUE:  mul_peak = peak_sat[2];
         default:  mul_peak = '0;
      endcase
   end
   assign prod = sine_ff * mul_peak;

   // mode change events
   assign off_change = (prev_mode_ff != mode_ff) && (mode_ff == MODE_OFF);
   assign on_load    = (mode_ff == MODE_ON) &&
                       ((prev_mode_ff != mode_ff) || (prev_color_ff != color_ff));

   // configuration writes
   always_comb begin
      slow_period_in = slow_period_ff;
      fast_period_in = fast_period_ff;
      for (int i = 0; i < 3; i++) begin
         peak_in[i] = peak_ff[i];
      end
      if (csr_wen) begin
         case (csr_addr)
            CSR_SLOW_PERIOD: slow_period_in = csr_wdata;
            CSR_FAST_PERIOD: fast_period_in = csr_wdata;
            CSR_RED_PEAK:    peak_in[0]     = csr_wdata[DUTY_W-1:0];
            CSR_GREEN_PEAK:  peak_in[1]     = csr_wdata[DUTY_W-1:0];
            CSR_BLUE_PEAK:   peak_in[2]     = csr_wdata[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   // block state next values
   always_comb begin
      color_in      = color_ff;
      mode_in       = mode_ff;
      prev_color_in = prev_color_ff;
      prev_mode_in  = prev_mode_ff;
      last_in       = last_ff;
      running_in    = running_ff;
      tick_in       = tick_ff;
      step_in       = step_ff;
      idx_in        = idx_ff;
      sine_in       = sine_ff;
      rsp_in        = rsp_ff;
      for (int i = 0; i < 3; i++) begin
         duty_in[i] = duty_ff[i];
      end

      // take in a word
      if (cmd.accept) begin
         tick_in = req_tdata[36:5];
         if (req_tuser) begin
            color_in = req_tdata[2:0];
            mode_in  = req_tdata[4:3];
         end
      end

      // glow phase arithmetic
      if (cmd.step_load) begin
         step_in = PERIOD_W'(step_prod >> RECIP_SH);
      end
      if (cmd.idx_load) begin
         idx_in = (q >= STEPS_Q) ? IDX_W'(q - STEPS_Q) : IDX_W'(q);
      end
      if (cmd.sine_load) begin
         sine_in = sine_q15(SINE_IDX_W'(idx_ff));
      end
      if (cmd.mul_en) begin
         for (int i = 0; i < 3; i++) begin
            if (cmd.ch == 2'(i)) begin
               duty_in[i] = en[i] ? prod[SINE_W+DUTY_W-2:SINE_W-1] : '0;
            end
         end
      end
      if (cmd.glow_commit) begin
         running_in = 1'b1;
         last_in    = tick_ff;
      end

      // stop and steady-on handling, then remember color and mode
      if (cmd.fin) begin
         if (off_change) begin
            running_in = 1'b0;
         end
         if (on_load) begin
            for (int i = 0; i < 3; i++) begin
               duty_in[i] = en[i] ? peak_sat[i] : '0;
            end
            running_in = 1'b1;
         end
         prev_color_in = color_ff;
         prev_mode_in  = mode_ff;
      end

      // result word
      if (cmd.out_load) begin
         rsp_in = {{(RSP_DATA_W-3*DUTY_W-1){1'b0}}, running_ff,
                   duty_ff[2], duty_ff[1], duty_ff[0]};
      end
   end

   // registers with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         slow_period_ff <= SLOW_PERIOD_RST;
         fast_period_ff <= FAST_PERIOD_RST;
         peak_ff[0]     <= RED_PEAK_RST;
         peak_ff[1]     <= GREEN_PEAK_RST;
         peak_ff[2]     <= BLUE_PEAK_RST;
         color_ff       <= '0;
         mode_ff        <= MODE_OFF;
         prev_color_ff  <= '0;
         prev_mode_ff   <= MODE_OFF;
         last_ff        <= '0;
         running_ff     <= 1'b1;
         for (int i = 0; i < 3; i++) begin
            duty_ff[i] <= '0;
         end
      end else begin
         slow_period_ff <= slow_period_in;
         fast_period_ff <= fast_period_in;
         color_ff       <= color_in;
         mode_ff        <= mode_in;
         prev_color_ff  <= prev_color_in;
         prev_mode_ff   <= prev_mode_in;
         last_ff        <= last_in;
         running_ff     <= running_in;
         for (int i = 0; i < 3; i++) begin
            peak_ff[i] <= peak_in[i];
            duty_ff[i] <= duty_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tick_ff <= tick_in;
      step_ff <= step_in;
      idx_ff  <= idx_in;
      sine_ff <= sine_in;
      rsp_ff  <= rsp_in;
   end

   // status back to the controller
   assign status.glow     = mode_ff[1];
   assign status.over     = elapsed > {{(TICK_W-PERIOD_W){1'b0}}, step_ff};
   assign status.div_done = div_done;

   assign rsp_tdata = rsp_ff;

endmodule

>>> rtl/rlb_ctrl.sv
// rlb_ctrl: sequencer for one word: divider passes, channel multiplies,
// state update and result handoff; uses rlb_pkg command and status types
module rlb_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  rlb_pkg::dp_status_type    status,
   output rlb_pkg::ctrl_cmd_type     cmd
);
   import rlb_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_STEP     = 4'd1;
   localparam logic [3:0] S_CHECK    = 4'd3;
   localparam logic [3:0] S_DIV_MOD  = 4'd4;
   localparam logic [3:0] S_DIV_IDX  = 4'd5;
   localparam logic [3:0] S_SINE     = 4'd6;
   localparam logic [3:0] S_MUL      = 4'd7;
   localparam logic [3:0] S_FIN      = 4'd8;
   localparam logic [3:0] S_OUT      = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [1:0] ch_ff, ch_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // sequencing
   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      cmd      = '0;
      cmd.ch   = ch_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_STEP;
            end
         end
         S_STEP: begin
            if (status.glow) begin
               cmd.step_load = 1'b1;
               state_in      = S_CHECK;
            end else begin
               state_in = S_FIN;
            end
         end
         S_CHECK: begin
            if (status.over) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_MOD;
               state_in      = S_DIV_MOD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DIV_MOD: begin
            cmd.div_sel = DIV_IDX;
            if (status.div_done) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV_IDX;
            end
         end
         S_DIV_IDX: begin
            if (status.div_done) begin
               cmd.idx_load = 1'b1;
               state_in     = S_SINE;
            end
         end
         S_SINE: begin
            cmd.sine_load = 1'b1;
            ch_in         = CH_RED;
            state_in      = S_MUL;
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            if (ch_ff == CH_BLUE) begin
               cmd.glow_commit = 1'b1;
               state_in        = S_FIN;
            end else begin
               ch_in = ch_ff + 2'd1;
            end
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result valid: set on load, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= CH_RED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule
